// ===== src/pbpm_pkg.sv =====
// Shared types and constants of the page buffer pool manager.
package pbpm_pkg;
    localparam int FRAMES = 32;
    localparam int FW = $clog2(FRAMES);
    localparam int QDEPTH = 2;
    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_PIN = 3'd0, REQ_ALLOC = 3'd1, REQ_DIRTY = 3'd2, REQ_UNPIN = 3'd3,
        REQ_FLUSH = 3'd4, REQ_FORCE = 3'd5, REQ_CLEAR = 3'd6, REQ_NOP = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOBUF = 3'd1, ST_INBUF = 3'd2, ST_NOTINBUF = 3'd3,
        ST_UNPINNED = 3'd4, ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0, ACT_FETCH = 2'd1, ACT_WRITE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE, S_SCAN, S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  file_id;
        logic [23:0] page_num;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  frame;
        logic [1:0]  action;
        logic [7:0]  out_file;
        logic [23:0] out_page;
        logic        last;
    } t_rsp_item;

    // classified request passed from front to back
    typedef struct packed {
        t_req        req;
        logic [7:0]  file_id;
        logic [23:0] page_num;
        logic        is_scan;
    } t_cmd;
endpackage

// ===== src/pbpm_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface pbpm_req_if (input logic i_clk);
    logic valid;
    logic ready;
    pbpm_pkg::t_req_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbpm_rsp_if (input logic i_clk);
    logic valid;
    logic ready;
    pbpm_pkg::t_rsp_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/pbpm_front.sv =====
// Request intake: classify and queue commands for the frame engine.
module pbpm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbpm_req_if.sink          req,
    output pbpm_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);
    import pbpm_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.req      = t_req'(req.data.req_type);
        w_cmd.file_id  = req.data.file_id;
        w_cmd.page_num = req.data.page_num;
        w_cmd.is_scan  = (w_cmd.req == REQ_FLUSH) || (w_cmd.req == REQ_FORCE) ||
                         (w_cmd.req == REQ_CLEAR);
    end

    assign req.ready   = (r_cnt != 2'd2);
    assign w_push      = req.valid && req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop of empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !req.ready) else $error("accept while full");
endmodule

// ===== src/pbpm_back.sv =====
// Frame table engine: lookups, claims and write-back scans.
module pbpm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbpm_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    pbpm_rsp_if.source        rsp
);
    import pbpm_pkg::*;

    logic [FRAMES-1:0] r_valid, r_dirty;
    logic [7:0]        r_file [FRAMES];
    logic [23:0]       r_page [FRAMES];
    logic [15:0]       r_pin  [FRAMES];

    t_state            r_state, n_state;
    logic [FW-1:0]     r_idx;
    logic              r_any;
    logic              r_ov, n_ov;
    t_rsp_item         r_out, n_out;
    logic [FRAMES-1:0] w_hit, w_free, w_match, w_later;
    logic              w_hit_any, w_free_any, w_later_any;
    logic [FW-1:0]     w_hit_idx, w_free_idx;
    logic              w_take;

    always_comb begin
        w_hit_idx = '0; w_free_idx = '0; w_hit_any = 1'b0; w_free_any = 1'b0;
        for (int i = 0; i < FRAMES; i++) begin
            w_hit[i]  = r_valid[i] && r_file[i] == i_cmd.file_id &&
                        r_page[i] == i_cmd.page_num;
            w_free[i] = (r_pin[i] == 16'd0);
        end
        for (int i = FRAMES-1; i >= 0; i--) begin
            if (w_hit[i]) begin w_hit_any = 1'b1; w_hit_idx = FW'(i); end
            if (w_free[i]) begin w_free_any = 1'b1; w_free_idx = FW'(i); end
        end
        w_match = '0;
        for (int i = 0; i < FRAMES; i++)
            w_match[i] = r_valid[i] && r_file[i] == i_cmd.file_id &&
                         (i_cmd.req != REQ_FORCE || r_page[i] == i_cmd.page_num);
        // dirty matches still ahead of the scan position
        for (int i = 0; i < FRAMES; i++)
            w_later[i] = w_match[i] && r_dirty[i] && (i > int'(r_idx));
        w_later_any = |w_later;
    end

    // output register drains on take; single item in flight
    assign rsp.valid = r_ov;
    assign rsp.data  = r_out;
    assign w_take    = r_ov && rsp.ready;

    always_comb begin
        n_state   = r_state;
        n_ov      = r_ov && !rsp.ready;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_ov) begin
                    n_out = '{status: ST_OK, frame: '0, action: ACT_NONE,
                              out_file: '0, out_page: '0, last: 1'b1};
                    if (i_cmd.is_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_ov = 1'b1;
                        case (i_cmd.req)
                            REQ_PIN, REQ_ALLOC: begin
                                if (w_hit_any) begin
                                    n_out.frame = 6'(w_hit_idx);
                                    if (i_cmd.req == REQ_ALLOC)
                                        n_out.status = ST_INBUF;
                                    else if (r_pin[w_hit_idx] == PIN_MAX)
                                        n_out.status = ST_OVERFLOW;
                                end else if (!w_free_any) begin
                                    n_out.status = ST_NOBUF;
                                end else begin
                                    n_out.frame = 6'(w_free_idx);
                                    if (i_cmd.req == REQ_PIN) begin
                                        n_out.action   = ACT_FETCH;
                                        n_out.out_file = i_cmd.file_id;
                                        n_out.out_page = i_cmd.page_num;
                                    end
                                end
                            end
                            REQ_DIRTY, REQ_UNPIN: begin
                                if (!w_hit_any) n_out.status = ST_NOTINBUF;
                                else begin
                                    n_out.frame = 6'(w_hit_idx);
                                    if (r_pin[w_hit_idx] == 16'd0)
                                        n_out.status = ST_UNPINNED;
                                    else if (i_cmd.req == REQ_UNPIN &&
                                             r_pin[w_hit_idx] == 16'd1 &&
                                             r_dirty[w_hit_idx]) begin
                                        n_out.action   = ACT_WRITE;
                                        n_out.out_file = i_cmd.file_id;
                                        n_out.out_page = i_cmd.page_num;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                // one frame per cycle; hold while the output register is full and not being taken
                if (!r_ov || rsp.ready) begin
                    if (w_match[r_idx] && r_dirty[r_idx]) begin
                        n_ov = 1'b1;
                        n_out = '{status: ST_OK, frame: 6'(r_idx), action: ACT_WRITE,
                                  out_file: i_cmd.file_id, out_page: r_page[r_idx],
                                  last: !w_later_any};
                    end
                    if (r_idx == FW'(FRAMES-1)) n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_any) begin
                    // final write-back already carries last
                    o_cmd_pop = 1'b1; n_state = S_IDLE;
                end else if (!r_ov || rsp.ready) begin
                    n_ov = 1'b1;
                    n_out = '{status: ST_OK, frame: '0, action: ACT_NONE,
                              out_file: '0, out_page: '0, last: 1'b1};
                    o_cmd_pop = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_idx <= '0; r_any <= 1'b0;
            r_valid <= '0; r_dirty <= '0;
            for (int i = 0; i < FRAMES; i++) r_pin[i] <= 16'd0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_out   <= n_out;
            if (r_state == S_IDLE) begin
                r_idx <= '0; r_any <= 1'b0;
                if (o_cmd_pop) begin
                    case (i_cmd.req)
                        REQ_PIN, REQ_ALLOC: begin
                            if (w_hit_any) begin
                                if (i_cmd.req == REQ_PIN && r_pin[w_hit_idx] != PIN_MAX)
                                    r_pin[w_hit_idx] <= r_pin[w_hit_idx] + 16'd1;
                            end else if (w_free_any) begin
                                r_valid[w_free_idx] <= 1'b1;
                                r_file[w_free_idx]  <= i_cmd.file_id;
                                r_page[w_free_idx]  <= i_cmd.page_num;
                                r_pin[w_free_idx]   <= 16'd1;
                                r_dirty[w_free_idx] <= 1'b0;
                            end
                        end
                        REQ_DIRTY: if (w_hit_any && r_pin[w_hit_idx] != 16'd0)
                            r_dirty[w_hit_idx] <= 1'b1;
                        REQ_UNPIN: if (w_hit_any && r_pin[w_hit_idx] != 16'd0) begin
                            r_pin[w_hit_idx] <= r_pin[w_hit_idx] - 16'd1;
                            if (r_pin[w_hit_idx] == 16'd1) r_dirty[w_hit_idx] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
            end else if (r_state == S_SCAN && (!r_ov || rsp.ready)) begin
                if (r_idx != FW'(FRAMES-1)) r_idx <= r_idx + FW'(1);
                if (w_match[r_idx]) begin
                    if (r_dirty[r_idx]) begin r_dirty[r_idx] <= 1'b0; r_any <= 1'b1; end
                    if (i_cmd.req == REQ_CLEAR) begin
                        r_valid[r_idx] <= 1'b0; r_pin[r_idx] <= 16'd0;
                    end
                end
            end
        end
    end

    a_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> i_cmd_valid) else $error("pop without command");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !rsp.ready) |=> r_ov) else $error("result dropped");
    a_scan_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (i_cmd_valid && i_cmd.is_scan))
        else $error("scan without scan command");
    a_claim_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && rsp.data.action == ACT_FETCH) |-> rsp.data.last)
        else $error("fetch not final");
endmodule

// ===== src/page_buffer_pool_manager.sv =====
// Top level of the page buffer pool manager.
// Lookup requests (pin, alloc, mark-dirty, unpin) give one result each; a new lookup
//   waits until the single output register is empty, its last result taken.
// Flush, force and clear scan one frame per cycle while the output register is free,
//   with one write-back result per matching dirty frame.
// Synchronous active-low reset frees all frames, clears pins, dirty bits and queue.
module page_buffer_pool_manager (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbpm_req_if.sink   i_req,
    pbpm_rsp_if.source o_rsp
);
    import pbpm_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_pop;

    // front: take items and queue classified commands
    pbpm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(i_req),
        .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid), .i_cmd_pop(w_cmd_pop)
    );

    // back: frame table, lookups, claims and scans
    pbpm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_cmd_valid(w_cmd_valid), .o_cmd_pop(w_cmd_pop), .rsp(o_rsp)
    );
endmodule

// ===== verif/tb_page_buffer_pool_manager.sv =====
// Testbench for the page buffer pool manager: requests checked against a frame table model.
module tb_page_buffer_pool_manager;
    import pbpm_pkg::*;

    logic i_clk;
    logic i_rst_n;

    pbpm_req_if req_ch (i_clk);
    pbpm_rsp_if rsp_ch (i_clk);

    page_buffer_pool_manager uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    localparam int CYCLE_LIMIT = 400000;

    // model of the frame table
    logic        tbl_valid [FRAMES];
    logic [7:0]  tbl_file  [FRAMES];
    logic [23:0] tbl_page  [FRAMES];
    logic [15:0] tbl_pins  [FRAMES];
    logic        tbl_dirty [FRAMES];

    t_rsp_item pending_rsp[$];
    int        fail_count;
    int        cycle_count;
    int        long_hold;       // receiver hold-off in cycles, counted down by the sink
    bit        sink_quiet;      // no random stalls on the result side
    bit        src_quiet;       // no random gaps on the request side

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_rsp_item mk_rsp(t_status st, int fr, t_action act,
                                         logic [7:0] f, logic [23:0] p, bit lst);
        t_rsp_item r;
        r.status   = st;
        r.frame    = fr[5:0];
        r.action   = act;
        r.out_file = f;
        r.out_page = p;
        r.last     = lst;
        return r;
    endfunction

    function automatic int find_frame(logic [7:0] f, logic [23:0] p);
        for (int i = 0; i < FRAMES; i++)
            if (tbl_valid[i] && tbl_file[i] == f && tbl_page[i] == p) return i;
        return -1;
    endfunction

    // take the lowest frame with no pins
    function automatic int take_frame(logic [7:0] f, logic [23:0] p);
        for (int i = 0; i < FRAMES; i++)
            if (tbl_pins[i] == 16'd0) begin
                tbl_valid[i] = 1'b1;
                tbl_file[i]  = f;
                tbl_page[i]  = p;
                tbl_pins[i]  = 16'd1;
                tbl_dirty[i] = 1'b0;
                return i;
            end
        return -1;
    endfunction

    // advance the table and queue the expected results of one request
    function automatic void predict_request(t_req_item it);
        int idx;
        int n;
        logic [7:0]  f;
        logic [23:0] p;
        f = it.file_id;
        p = it.page_num;
        case (it.req_type)
            REQ_PIN: begin
                idx = find_frame(f, p);
                if (idx >= 0) begin
                    if (tbl_pins[idx] == PIN_MAX)
                        pending_rsp.push_back(mk_rsp(ST_OVERFLOW, idx, ACT_NONE, 0, 0, 1));
                    else begin
                        tbl_pins[idx]++;
                        pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_NONE, 0, 0, 1));
                    end
                end else begin
                    idx = take_frame(f, p);
                    if (idx < 0) pending_rsp.push_back(mk_rsp(ST_NOBUF, 0, ACT_NONE, 0, 0, 1));
                    else pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_FETCH, f, p, 1));
                end
            end
            REQ_ALLOC: begin
                idx = find_frame(f, p);
                if (idx >= 0) pending_rsp.push_back(mk_rsp(ST_INBUF, idx, ACT_NONE, 0, 0, 1));
                else begin
                    idx = take_frame(f, p);
                    if (idx < 0) pending_rsp.push_back(mk_rsp(ST_NOBUF, 0, ACT_NONE, 0, 0, 1));
                    else pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_NONE, 0, 0, 1));
                end
            end
            REQ_DIRTY, REQ_UNPIN: begin
                idx = find_frame(f, p);
                if (idx < 0)
                    pending_rsp.push_back(mk_rsp(ST_NOTINBUF, 0, ACT_NONE, 0, 0, 1));
                else if (tbl_pins[idx] == 16'd0)
                    pending_rsp.push_back(mk_rsp(ST_UNPINNED, idx, ACT_NONE, 0, 0, 1));
                else if (it.req_type == REQ_DIRTY) begin
                    tbl_dirty[idx] = 1'b1;
                    pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_NONE, 0, 0, 1));
                end else begin
                    tbl_pins[idx]--;
                    if (tbl_pins[idx] == 16'd0 && tbl_dirty[idx]) begin
                        tbl_dirty[idx] = 1'b0;
                        pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_WRITE, f, p, 1));
                    end else
                        pending_rsp.push_back(mk_rsp(ST_OK, idx, ACT_NONE, 0, 0, 1));
                end
            end
            REQ_FLUSH, REQ_FORCE, REQ_CLEAR: begin
                n = 0;
                for (int i = 0; i < FRAMES; i++) begin
                    if (!tbl_valid[i] || tbl_file[i] != f) continue;
                    if (it.req_type == REQ_FORCE && tbl_page[i] != p) continue;
                    if (tbl_dirty[i]) begin
                        tbl_dirty[i] = 1'b0;
                        pending_rsp.push_back(mk_rsp(ST_OK, i, ACT_WRITE, f, tbl_page[i], 0));
                        n++;
                    end
                    if (it.req_type == REQ_CLEAR) begin
                        tbl_valid[i] = 1'b0;
                        tbl_file[i]  = '0;
                        tbl_page[i]  = '0;
                        tbl_pins[i]  = '0;
                    end
                end
                // last flag goes on the final write-back of the scan
                if (n == 0) pending_rsp.push_back(mk_rsp(ST_OK, 0, ACT_NONE, 0, 0, 1));
                else pending_rsp[$].last = 1'b1;
            end
            default: pending_rsp.push_back(mk_rsp(ST_OK, 0, ACT_NONE, 0, 0, 1));
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_request(t_req rt, logic [7:0] f, logic [23:0] p);
        t_req_item it;
        int gap;
        it.req_type = rt;
        it.file_id  = f;
        it.page_num = p;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(it);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        drop_valid();
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // result side: random stall, an occasional long one, or a requested hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else if (sink_quiet) rsp_ch.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 2) begin
            long_hold <= $urandom_range(8, 30);
            rsp_ch.ready <= 1'b0;
        end else rsp_ch.ready <= ($urandom_range(0, 99) < 70);
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp_item exp_r;
        t_rsp_item got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                fail_count++;
            end else begin
                exp_r = pending_rsp.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    fail_count++;
                end
                if (got.frame !== exp_r.frame) begin
                    $display("%0t: frame exp %0d got %0d", $time, exp_r.frame, got.frame);
                    fail_count++;
                end
                if (got.action !== exp_r.action) begin
                    $display("%0t: action exp %0d got %0d", $time, exp_r.action, got.action);
                    fail_count++;
                end
                if (got.out_file !== exp_r.out_file) begin
                    $display("%0t: out_file exp %0h got %0h", $time, exp_r.out_file,
                             got.out_file);
                    fail_count++;
                end
                if (got.out_page !== exp_r.out_page) begin
                    $display("%0t: out_page exp %0h got %0h", $time, exp_r.out_page,
                             got.out_page);
                    fail_count++;
                end
                if (got.last !== exp_r.last) begin
                    $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // extremes, every request type, and the named corner cases
    task automatic test_directed();
        send_request(REQ_FLUSH, 8'hFF, 24'h0);           // scan with nothing to write
        send_request(REQ_UNPIN, 8'h00, 24'h0);           // not buffered
        send_request(REQ_PIN, 8'hFF, 24'hFFFFFF);        // miss, fetch
        send_request(REQ_PIN, 8'hFF, 24'hFFFFFF);        // hit, second pin
        send_request(REQ_ALLOC, 8'hFF, 24'hFFFFFF);      // already buffered
        send_request(REQ_ALLOC, 8'h00, 24'h000000);      // claim without fetch
        send_request(REQ_DIRTY, 8'hFF, 24'hFFFFFF);
        send_request(REQ_UNPIN, 8'hFF, 24'hFFFFFF);
        send_request(REQ_UNPIN, 8'hFF, 24'hFFFFFF);      // reaches zero, write-back
        send_request(REQ_UNPIN, 8'hFF, 24'hFFFFFF);      // unpin at zero
        send_request(REQ_DIRTY, 8'hFF, 24'hFFFFFF);      // unpinned page
        send_request(REQ_PIN, 8'hFF, 24'hFFFFFF);        // re-pin a kept tag
        send_request(REQ_DIRTY, 8'hFF, 24'hFFFFFF);
        send_request(REQ_FORCE, 8'hFF, 24'hFFFFFF);      // write-back while pinned
        send_request(REQ_DIRTY, 8'h00, 24'h000000);
        send_request(REQ_DIRTY, 8'hAA, 24'h555555);      // not buffered
        send_request(REQ_FLUSH, 8'h00, 24'h123456);
        send_request(REQ_DIRTY, 8'hFF, 24'hFFFFFF);
        send_request(REQ_CLEAR, 8'hFF, 24'h0);           // frees a pinned frame
        send_request(REQ_NOP, 8'h5A, 24'hA5A5A5);        // ignored type
        send_request(REQ_CLEAR, 8'h00, 24'hFFFFFF);
        wait_drain();
    endtask

    // fill every frame, then ask once more for no free frame
    task automatic test_pool_full();
        for (int i = 0; i < FRAMES; i++) begin
            send_request(REQ_PIN, 8'h11, 24'(i));
            if (i % 3 == 0) send_request(REQ_DIRTY, 8'h11, 24'(i));
        end
        send_request(REQ_PIN, 8'h22, 24'h0);
        send_request(REQ_ALLOC, 8'h22, 24'h1);
        send_request(REQ_FLUSH, 8'h11, 24'h0);           // many write-backs
        send_request(REQ_CLEAR, 8'h11, 24'h0);
        wait_drain();
    endtask

    // hold the result side off so the block fills and stalls its input
    task automatic test_backpressure();
        @(negedge i_clk);
        long_hold = 120;
        for (int i = 0; i < 20; i++)
            send_request(t_req'($urandom_range(0, 3)), 8'h44, 24'($urandom_range(0, 3)));
        wait_drain();
    endtask

    // mostly sessions on a few files and pages; some noise over full ranges
    task automatic test_random();
        t_req rt;
        logic [7:0]  f;
        logic [23:0] p;
        for (int n = 0; n < 380; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                f  = 8'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'hF0 : 8'h0F);
                p  = 24'($urandom_range(0, 11)) | ($urandom_range(0, 1) ? 24'hFFFF00 : 24'h0);
                rt = t_req'($urandom_range(0, 99) < 85 ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 6));
            end else begin
                f  = 8'($urandom);
                p  = 24'($urandom);
                rt = t_req'($urandom_range(0, 7));
            end
            send_request(rt, f, p);
        end
        wait_drain();
    endtask

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        long_hold     = 0;
        sink_quiet    = 1'b0;
        src_quiet     = 1'b0;
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        for (int i = 0; i < FRAMES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_file[i]  = '0;
            tbl_page[i]  = '0;
            tbl_pins[i]  = '0;
            tbl_dirty[i] = 1'b0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random();
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
